### rtl/les_pkg.sv
package les_pkg;

  localparam int unsigned AddrW = 6;
  localparam int unsigned DataW = 64;

  localparam logic [2:0] RegControl     = 3'd0;
  localparam logic [2:0] RegPeriod      = 3'd1;
  localparam logic [2:0] RegOnDuration  = 3'd2;
  localparam logic [2:0] RegDelayBefore = 3'd3;
  localparam logic [2:0] RegDelayAfter  = 3'd4;
  localparam logic [2:0] RegRepetitions = 3'd5;
  localparam logic [2:0] RegTableLow    = 3'd6;
  localparam logic [2:0] RegTableLast   = 3'd7;

  localparam logic [2:0] EffOff     = 3'd0;
  localparam logic [2:0] EffOn      = 3'd1;
  localparam logic [2:0] EffBlink   = 3'd2;
  localparam logic [2:0] EffBreathe = 3'd3;
  localparam logic [2:0] EffFadeOn  = 3'd4;
  localparam logic [2:0] EffFadeOff = 3'd5;

  localparam logic [1:0] ModeAdvance = 2'd0;
  localparam logic [1:0] ModeStart   = 2'd1;
  localparam logic [1:0] ModeStop    = 2'd2;

  localparam logic [15:0] ForeverCount = 16'hFFFF;
  localparam logic [7:0]  FullLevel    = 8'hFF;

  localparam int unsigned DivW = 17;

  typedef struct packed {
    logic [2:0]  effect;
    logic        invert;
    logic        low_active;
    logic [15:0] period_ticks;
    logic [15:0] on_duration;
    logic [15:0] lead_ticks;
    logic [15:0] gap_ticks;
    logic [15:0] repetitions;
    logic [63:0] table_low;
    logic [7:0]  table_last;
  } cfg_t;

endpackage

### rtl/les_regs.sv
module les_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [les_pkg::AddrW-1:0]   paddr,
  input  logic [les_pkg::DataW-1:0]   pwdata,
  output logic [les_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output les_pkg::cfg_t               cfg_o
);

  les_pkg::cfg_t cfg_q;
  logic [2:0]    idx;
  logic          wr_en;

  assign idx    = paddr[les_pkg::AddrW-1:3];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.effect       <= les_pkg::EffOff;
      cfg_q.invert       <= 1'b0;
      cfg_q.low_active   <= 1'b0;
      cfg_q.period_ticks <= 16'd1;
      cfg_q.on_duration  <= 16'd0;
      cfg_q.lead_ticks   <= 16'd0;
      cfg_q.gap_ticks    <= 16'd0;
      cfg_q.repetitions  <= 16'd1;
      cfg_q.table_low    <= 64'd0;
      cfg_q.table_last   <= les_pkg::FullLevel;
    end else if (wr_en) begin
      unique case (idx)
        les_pkg::RegControl: begin
          cfg_q.effect     <= pwdata[2:0];
          cfg_q.invert     <= pwdata[3];
          cfg_q.low_active <= pwdata[4];
        end
        les_pkg::RegPeriod:      cfg_q.period_ticks <= pwdata[15:0];
        les_pkg::RegOnDuration:  cfg_q.on_duration  <= pwdata[15:0];
        les_pkg::RegDelayBefore: cfg_q.lead_ticks   <= pwdata[15:0];
        les_pkg::RegDelayAfter:  cfg_q.gap_ticks    <= pwdata[15:0];
        les_pkg::RegRepetitions: cfg_q.repetitions  <= pwdata[15:0];
        les_pkg::RegTableLow:    cfg_q.table_low    <= pwdata;
        les_pkg::RegTableLast:   cfg_q.table_last   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      les_pkg::RegControl:     prdata[4:0]  = {cfg_q.low_active, cfg_q.invert, cfg_q.effect};
      les_pkg::RegPeriod:      prdata[15:0] = cfg_q.period_ticks;
      les_pkg::RegOnDuration:  prdata[15:0] = cfg_q.on_duration;
      les_pkg::RegDelayBefore: prdata[15:0] = cfg_q.lead_ticks;
      les_pkg::RegDelayAfter:  prdata[15:0] = cfg_q.gap_ticks;
      les_pkg::RegRepetitions: prdata[15:0] = cfg_q.repetitions;
      les_pkg::RegTableLow:    prdata       = cfg_q.table_low;
      les_pkg::RegTableLast:   prdata[7:0]  = cfg_q.table_last;
      default: ;
    endcase
  end

endmodule

### rtl/les_div_step.sv
module les_div_step (
  input  logic [les_pkg::DivW-1:0] rem_i,
  input  logic                     bit_i,
  input  logic [les_pkg::DivW-1:0] divisor_i,
  output logic [les_pkg::DivW-1:0] rem_o,
  output logic                     q_bit_o
);

  logic [les_pkg::DivW:0] shifted;
  logic [les_pkg::DivW:0] diff;

  // one restoring step: remainder stays below the divisor
  assign shifted = {rem_i, bit_i};
  assign diff    = shifted - {1'b0, divisor_i};
  assign q_bit_o = (shifted >= {1'b0, divisor_i});
  assign rem_o   = q_bit_o ? diff[les_pkg::DivW-1:0] : shifted[les_pkg::DivW-1:0];

endmodule

### rtl/les_interp.sv
module les_interp (
  input  logic [7:0]  pos_i,
  input  logic [63:0] table_low_i,
  input  logic [7:0]  table_last_i,
  output logic [7:0]  level_o
);

  logic [2:0]         seg;
  logic [4:0]         dx;
  logic [7:0]         y0;
  logic [7:0]         y1;
  logic signed [9:0]  dy;
  logic signed [15:0] prod;
  logic signed [15:0] step;

  assign seg  = pos_i[7:5];
  assign dx   = pos_i[4:0];
  assign y0   = table_low_i[{seg, 3'b000} +: 8];
  assign y1   = (seg == 3'd7) ? table_last_i : table_low_i[{seg + 3'd1, 3'b000} +: 8];
  assign dy   = $signed({2'b00, y1}) - $signed({2'b00, y0});
  assign prod = $signed({11'd0, dx}) * $signed({{6{dy[9]}}, dy});
  // floor division by 32
  assign step = prod >>> 5;
  assign level_o = y0 + step[7:0];

endmodule

### rtl/led_effect_sequencer.sv
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   mode_i[1:0], elapsed_i[15:0]
// out       output     out_valid_o / out_ready_i level_o[7:0], finished_o
// cfg       input      APB psel/penable/pwrite   paddr[5:0], pwdata[63:0], prdata[63:0]
//
// One transaction at a time; in_ready_o is high only while the sequencer idles.
// A stop goes straight to the output. Otherwise the lead-in check, the repetition limit,
// the modulo and the gap test come before the level; a final write skips the modulo and
// the gap test, and a fade adds a quotient and an interpolation. Both share the divider step.
// A result waits in the output register while the next item is taken; a second result
// stalls the sequencer until it drains. Asynchronous active-low reset; no clearing pass.
module led_effect_sequencer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                mode_i,
  input  logic [15:0]               elapsed_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [7:0]                level_o,
  output logic                      finished_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [les_pkg::AddrW-1:0] paddr,
  input  logic [les_pkg::DataW-1:0] pwdata,
  output logic [les_pkg::DataW-1:0] prdata,
  output logic                      pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_LIMIT, S_MOD, S_GAP, S_LEVEL, S_FADE, S_INTERP, S_EMIT
  } state_e;

  les_pkg::cfg_t cfg;

  state_e                  state_q;
  logic                    running_q;
  logic                    in_gap_q;
  logic [31:0]             ticks_q;
  logic [31:0]             rel_q;
  logic [32:0]             prod_q;
  logic [les_pkg::DivW-1:0] rem_q;
  logic [les_pkg::DivW-1:0] div_q;
  logic [4:0]              cnt_q;
  logic [15:0]             t_q;
  logic [7:0]              s_q;
  logic [7:0]              v_q;
  logic                    fin_q;
  logic                    out_valid_q;
  logic [7:0]              level_q;
  logic                    finished_q;

  les_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // effective period and cycle length
  logic [15:0] p;
  logic [16:0] p17;
  logic [16:0] cyc;
  logic [15:0] p_m1;
  logic [32:0] ticks_sum;
  logic        accept;

  assign p = (cfg.effect == les_pkg::EffOff || cfg.effect == les_pkg::EffOn ||
              cfg.period_ticks == 16'd0) ? 16'd1 : cfg.period_ticks;
  assign p17       = {1'b0, p};
  assign p_m1      = p - 16'd1;
  assign cyc       = p17 + {1'b0, cfg.gap_ticks};
  assign ticks_sum = {1'b0, ticks_q} + {17'd0, elapsed_i};
  assign accept    = in_valid_i && in_ready_o;

  // shared divider step
  logic [les_pkg::DivW-1:0] rem_next;
  logic                     q_bit;

  les_div_step u_div (
    .rem_i     (rem_q),
    .bit_i     ((state_q == S_MOD) ? rel_q[31] : 1'b0),
    .divisor_i (div_q),
    .rem_o     (rem_next),
    .q_bit_o   (q_bit)
  );

  logic [7:0] interp_v;

  les_interp u_interp (
    .pos_i        (s_q),
    .table_low_i  (cfg.table_low),
    .table_last_i (cfg.table_last),
    .level_o      (interp_v)
  );

  // level selection at position t_q
  logic [16:0] t17;
  logic [15:0] half;
  logic [16:0] fx;
  logic [15:0] fq;
  logic        use_fade;
  logic [7:0]  const_v;
  logic        need_div;

  always_comb begin
    t17      = {1'b0, t_q};
    half     = p >> 1;
    fx       = t17;
    fq       = p;
    use_fade = 1'b0;
    const_v  = 8'd0;
    unique case (cfg.effect)
      les_pkg::EffOn:    const_v = les_pkg::FullLevel;
      les_pkg::EffBlink: const_v = (t_q < cfg.on_duration) ? les_pkg::FullLevel : 8'd0;
      les_pkg::EffBreathe: begin
        if (t17 + 17'd1 < p17) begin
          use_fade = 1'b1;
          fq       = half;
          fx       = (t_q < half) ? t17 : ({half, 1'b0} - t17);
        end
      end
      les_pkg::EffFadeOn: use_fade = 1'b1;
      les_pkg::EffFadeOff: begin
        use_fade = 1'b1;
        fx       = p17 - t17;
      end
      default: const_v = 8'd0;
    endcase
    need_div = 1'b0;
    if (use_fade) begin
      if (fq == 16'd0 || ({1'b0, fx} + 18'd1 >= {2'b00, fq})) begin
        const_v = les_pkg::FullLevel;
      end else begin
        need_div = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      running_q   <= 1'b0;
      in_gap_q    <= 1'b0;
      ticks_q     <= '0;
      rel_q       <= '0;
      prod_q      <= '0;
      rem_q       <= '0;
      div_q       <= '0;
      cnt_q       <= '0;
      t_q         <= '0;
      s_q         <= '0;
      v_q         <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
      level_q     <= '0;
      finished_q  <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != S_EMIT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (mode_i == les_pkg::ModeStop) begin
              running_q <= 1'b0;
              in_gap_q  <= 1'b0;
              // polarity at the output turns this into the low-active idle level
              v_q       <= {8{cfg.invert}};
              fin_q     <= 1'b1;
              state_q   <= S_EMIT;
            end else if (mode_i == les_pkg::ModeStart) begin
              running_q <= 1'b1;
              in_gap_q  <= 1'b0;
              ticks_q   <= '0;
              state_q   <= S_CHECK;
            end else if (mode_i == les_pkg::ModeAdvance && running_q &&
                         elapsed_i != 16'd0) begin
              ticks_q <= ticks_sum[32] ? 32'hFFFF_FFFF : ticks_sum[31:0];
              state_q <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (ticks_q < {16'd0, cfg.lead_ticks}) begin
            state_q <= S_IDLE;
          end else begin
            rel_q   <= ticks_q - {16'd0, cfg.lead_ticks};
            prod_q  <= {16'd0, cyc} * {17'd0, cfg.repetitions};
            state_q <= S_LIMIT;
          end
        end
        S_LIMIT: begin
          if (cfg.repetitions != les_pkg::ForeverCount && {1'b0, rel_q} >= prod_q) begin
            t_q       <= p_m1;
            fin_q     <= 1'b1;
            running_q <= 1'b0;
            in_gap_q  <= 1'b0;
            state_q   <= S_LEVEL;
          end else begin
            fin_q   <= 1'b0;
            rem_q   <= '0;
            div_q   <= cyc;
            cnt_q   <= 5'd31;
            state_q <= S_MOD;
          end
        end
        S_MOD: begin
          rem_q <= rem_next;
          rel_q <= {rel_q[30:0], 1'b0};
          cnt_q <= cnt_q - 5'd1;
          if (cnt_q == 5'd0) begin
            state_q <= S_GAP;
          end
        end
        S_GAP: begin
          if (rem_q < p17) begin
            in_gap_q <= 1'b0;
            t_q      <= rem_q[15:0];
            state_q  <= S_LEVEL;
          end else if (in_gap_q) begin
            state_q <= S_IDLE;
          end else begin
            in_gap_q <= 1'b1;
            t_q      <= p_m1;
            state_q  <= S_LEVEL;
          end
        end
        S_LEVEL: begin
          if (need_div) begin
            rem_q   <= fx;
            div_q   <= {1'b0, fq};
            cnt_q   <= 5'd7;
            state_q <= S_FADE;
          end else begin
            v_q     <= const_v;
            state_q <= S_EMIT;
          end
        end
        S_FADE: begin
          rem_q <= rem_next;
          s_q   <= {s_q[6:0], q_bit};
          cnt_q <= cnt_q - 5'd1;
          if (cnt_q == 5'd0) begin
            state_q <= S_INTERP;
          end
        end
        S_INTERP: begin
          v_q     <= interp_v;
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            level_q     <= v_q ^ {8{cfg.invert ^ cfg.low_active}};
            finished_q  <= fin_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign level_o     = level_q;
  assign finished_o  = finished_q;

  a_gap_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_gap_q |-> running_q)
    else $error("gap flag set without a running effect");

  a_fin_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && fin_q) |-> !running_q)
    else $error("final transaction pending while still running");

  a_mod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GAP) |-> (rem_q < div_q))
    else $error("modulo remainder not below cycle length");

  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && !out_valid_q) |=> out_valid_q)
    else $error("result not loaded into free output register");

endmodule

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam logic [1:0] ModeIgnored = 2'd3;
  localparam int InvertBit = 3;
  localparam int LowActiveBit = 4;

  typedef struct {
    bit [7:0] level;
    bit       finished;
  } level_write_t;

  class level_tracker;
    bit [4:0]  ctrl = 5'd0;
    bit [15:0] period_len = 16'd1;
    bit [15:0] on_len = 16'd0;
    bit [15:0] lead_in = 16'd0;
    bit [15:0] gap_len = 16'd0;
    bit [15:0] repeat_count = 16'd1;
    bit [63:0] curve_low = 64'd0;
    bit [7:0]  curve_top = 8'hff;
    bit        active = 1'b0;
    bit        gap_held = 1'b0;
    bit [31:0] tick_count = 32'd0;
    level_write_t due_levels[$];
    int unsigned mismatches = 0;

    function void write_register(logic [2:0] index, logic [63:0] value);
      case (index)
        les_pkg::RegControl:     ctrl = value[4:0];
        les_pkg::RegPeriod:      period_len = value[15:0];
        les_pkg::RegOnDuration:  on_len = value[15:0];
        les_pkg::RegDelayBefore: lead_in = value[15:0];
        les_pkg::RegDelayAfter:  gap_len = value[15:0];
        les_pkg::RegRepetitions: repeat_count = value[15:0];
        les_pkg::RegTableLow:    curve_low = value;
        les_pkg::RegTableLast:   curve_top = value[7:0];
        default: ;
      endcase
    endfunction

    function void expect_write(bit [7:0] level, bit finished);
      level_write_t w;
      w.level = level;
      w.finished = finished;
      due_levels.push_back(w);
    endfunction

    function bit [7:0] curve_point(bit [31:0] i);
      if (i >= 32'd8) return curve_top;
      return curve_low[i*8 +: 8];
    endfunction

    function bit [7:0] ramp_up(bit [31:0] t, bit [31:0] p);
      bit [31:0] s, seg, dx, sum;
      int y0, y1, d;
      if (p == 32'd0 || t + 32'd1 >= p || t + 32'd1 == 32'd0) return les_pkg::FullLevel;
      s = ((t << 8) / p) & 32'hff;
      seg = s >> 5;
      y0 = int'(curve_point(seg));
      y1 = int'(curve_point(seg + 32'd1));
      dx = s - (seg << 5);
      d = int'(dx) * (y1 - y0);
      sum = y0 + (d >>> 5);
      return sum[7:0];
    endfunction

    function bit [7:0] ramp_down(bit [31:0] t, bit [31:0] p);
      return ramp_up(p - t, p);
    endfunction

    function bit [31:0] period_used();
      if (ctrl[2:0] == les_pkg::EffOff || ctrl[2:0] == les_pkg::EffOn ||
          period_len == 16'd0) return 32'd1;
      return {16'd0, period_len};
    endfunction

    function bit [7:0] level_at(bit [31:0] t, bit [31:0] p);
      bit [7:0]  v;
      bit [31:0] h;
      case (ctrl[2:0])
        les_pkg::EffOn: v = les_pkg::FullLevel;
        les_pkg::EffBlink: v = (t < {16'd0, on_len}) ? les_pkg::FullLevel : 8'h00;
        les_pkg::EffBreathe: begin
          if (t + 32'd1 >= p) begin
            v = 8'h00;
          end else begin
            h = p >> 1;
            v = (t < h) ? ramp_up(t, h) : ramp_down(t - h, h);
          end
        end
        les_pkg::EffFadeOn: v = ramp_up(t, p);
        les_pkg::EffFadeOff: v = ramp_down(t, p);
        default: v = 8'h00;
      endcase
      if (ctrl[InvertBit]) v = les_pkg::FullLevel - v;
      if (ctrl[LowActiveBit]) v = les_pkg::FullLevel - v;
      return v;
    endfunction

    function void emit_due();
      bit [31:0] p, cyc, rel, t;
      bit [63:0] span;
      p = period_used();
      cyc = p + {16'd0, gap_len};
      if (tick_count < {16'd0, lead_in}) return;
      rel = tick_count - {16'd0, lead_in};
      span = {32'd0, cyc};
      span = span * {48'd0, repeat_count};
      if (repeat_count != les_pkg::ForeverCount && {32'd0, rel} >= span) begin
        expect_write(level_at(p - 32'd1, p), 1'b1);
        active = 1'b0;
        gap_held = 1'b0;
        return;
      end
      t = rel % cyc;
      if (t < p) begin
        gap_held = 1'b0;
        expect_write(level_at(t, p), 1'b0);
      end else if (!gap_held) begin
        gap_held = 1'b1;
        expect_write(level_at(p - 32'd1, p), 1'b0);
      end
    endfunction

    function void note_transaction(logic [1:0] mode, logic [15:0] elapsed);
      case (mode)
        les_pkg::ModeStop: begin
          active = 1'b0;
          gap_held = 1'b0;
          expect_write(ctrl[LowActiveBit] ? les_pkg::FullLevel : 8'h00, 1'b1);
        end
        les_pkg::ModeStart: begin
          active = 1'b1;
          tick_count = 32'd0;
          gap_held = 1'b0;
          emit_due();
        end
        les_pkg::ModeAdvance: begin
          if (active && elapsed != 16'd0) begin
            if (tick_count > 32'hffff_ffff - {16'd0, elapsed}) tick_count = 32'hffff_ffff;
            else tick_count += {16'd0, elapsed};
            emit_due();
          end
        end
        default: ;
      endcase
    endfunction

    function void check_transaction(logic [7:0] level, logic finished);
      level_write_t w;
      if (due_levels.size() == 0) begin
        $display("%0t: unexpected transaction: expected none, actual level %0d finished %0b",
                 $time, level, finished);
        mismatches++;
        return;
      end
      w = due_levels.pop_front();
      if (level !== w.level) begin
        $display("%0t: level: expected %0d, actual %0d", $time, w.level, level);
        mismatches++;
      end
      if (finished !== w.finished) begin
        $display("%0t: finished: expected %0b, actual %0b", $time, w.finished, finished);
        mismatches++;
      end
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic [1:0]                mode_i;
  logic [15:0]               elapsed_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic [7:0]                level_o;
  logic                      finished_o;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [les_pkg::AddrW-1:0] paddr;
  logic [les_pkg::DataW-1:0] pwdata;
  logic [les_pkg::DataW-1:0] prdata;
  logic                      pready;

  level_tracker levels;
  bit           idle_on = 1'b1;
  int unsigned  hold_out = 0;

  led_effect_sequencer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (mode_i),
    .elapsed_i  (elapsed_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .level_o    (level_o),
    .finished_o (finished_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #(20_000_000);
    $display("testbench NOT OK");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_ready_i === 1'b1)
      levels.check_transaction(level_o, finished_o);
  end

  // receiver: random back-pressure, plus long hold-offs on request
  initial begin : receiver
    int unsigned wait_left;
    bit          took;
    out_ready_i = 1'b0;
    wait_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      took = out_valid_o === 1'b1 && out_ready_i === 1'b1;
      @(negedge clk_i);
      if (took) wait_left = idle_on ? $urandom_range(4, 0) : 0;
      if (hold_out != 0) begin
        wait_left = hold_out;
        hold_out = 0;
      end
      if (wait_left != 0) begin
        out_ready_i <= 1'b0;
        wait_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_transaction(input logic [1:0] mode, input logic [15:0] elapsed);
    int unsigned gap;
    gap = idle_on ? $urandom_range(4, 0) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= mode;
    elapsed_i <= elapsed;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    levels.note_transaction(mode, elapsed);
    @(negedge clk_i);
  endtask

  task automatic settle_levels();
    in_valid_i <= 1'b0;
    while (levels.due_levels.size() != 0) @(negedge clk_i);
    repeat (64) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] index, input logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 3'b000};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    levels.write_register(index, value);
    @(negedge clk_i);
  endtask

  task automatic configure(input logic [4:0] ctl, input logic [15:0] per, on_t, dly_b, dly_a,
                           reps, input logic [63:0] tbl, input logic [7:0] top);
    settle_levels();
    apb_write(les_pkg::RegControl, {59'd0, ctl});
    apb_write(les_pkg::RegPeriod, {48'd0, per});
    apb_write(les_pkg::RegOnDuration, {48'd0, on_t});
    apb_write(les_pkg::RegDelayBefore, {48'd0, dly_b});
    apb_write(les_pkg::RegDelayAfter, {48'd0, dly_a});
    apb_write(les_pkg::RegRepetitions, {48'd0, reps});
    apb_write(les_pkg::RegTableLow, tbl);
    apb_write(les_pkg::RegTableLast, {56'd0, top});
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned counted, n, cyc, step_max, sel, eff;
    logic [4:0]  ctl;
    logic [15:0] per, on_t, dly_b, dly_a, reps, el;
    logic [1:0]  md;
    levels = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    mode_i = les_pkg::ModeAdvance;
    elapsed_i = 16'd0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: idle advance, ignored mode, stop, start, zero elapsed, end
    send_transaction(les_pkg::ModeAdvance, 16'd7);
    send_transaction(ModeIgnored, 16'hffff);
    send_transaction(les_pkg::ModeStop, 16'd0);
    send_transaction(les_pkg::ModeStart, 16'hffff);
    send_transaction(les_pkg::ModeAdvance, 16'd0);
    send_transaction(les_pkg::ModeAdvance, 16'd1);

    // inverted fade-on, uneven table, lead-in and gap, two periods
    configure({1'b0, 1'b1, les_pkg::EffFadeOn}, 16'd64, 16'd0, 16'd5, 16'd3, 16'd2,
              64'h40c0_30d0_20e0_10f0, 8'h80);
    send_transaction(les_pkg::ModeStart, 16'd0);
    send_transaction(les_pkg::ModeAdvance, 16'd4);
    send_transaction(les_pkg::ModeAdvance, 16'd1);
    send_transaction(les_pkg::ModeAdvance, 16'd33);
    send_transaction(les_pkg::ModeAdvance, 16'd30);
    send_transaction(les_pkg::ModeAdvance, 16'd1);
    send_transaction(les_pkg::ModeAdvance, 16'hffff);

    // zero period and zero repetitions, low-active stop
    configure({1'b1, 1'b0, les_pkg::EffBreathe}, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
              64'h0123_4567_89ab_cdef, 8'h00);
    send_transaction(les_pkg::ModeStart, 16'd0);
    send_transaction(les_pkg::ModeStop, 16'd0);

    // unused effect code, endless
    configure({1'b0, 1'b1, 3'd7}, 16'd100, 16'd0, 16'd0, 16'd0, les_pkg::ForeverCount,
              64'hffff_ffff_ffff_ffff, 8'hff);
    send_transaction(les_pkg::ModeStart, 16'd0);
    send_transaction(les_pkg::ModeAdvance, 16'hffff);
    send_transaction(les_pkg::ModeAdvance, 16'hffff);

    // blink with a long gap, held level written once
    configure({1'b1, 1'b1, les_pkg::EffBlink}, 16'd8, 16'd3, 16'd0, 16'hffff, 16'd3,
              64'd0, 8'hff);
    send_transaction(les_pkg::ModeStart, 16'd0);
    send_transaction(les_pkg::ModeAdvance, 16'd2);
    send_transaction(les_pkg::ModeAdvance, 16'd1);
    send_transaction(les_pkg::ModeAdvance, 16'd5);
    send_transaction(les_pkg::ModeAdvance, 16'd7);

    // widest fade-off with the longest lead-in
    configure({1'b0, 1'b0, les_pkg::EffFadeOff}, 16'hffff, 16'hffff, 16'hffff, 16'd0, 16'd1,
              64'h00ff_10ef_20df_30cf, 8'h7f);
    send_transaction(les_pkg::ModeStart, 16'd0);
    send_transaction(les_pkg::ModeAdvance, 16'hffff);
    send_transaction(les_pkg::ModeAdvance, 16'hfffe);
    send_transaction(les_pkg::ModeAdvance, 16'd1);

    // output held off while inputs keep arriving
    configure({1'b0, 1'b0, les_pkg::EffOn}, 16'd1, 16'd0, 16'd0, 16'd0, les_pkg::ForeverCount,
              {$urandom, $urandom}, 8'hff);
    idle_on = 1'b0;
    send_transaction(les_pkg::ModeStart, 16'd0);
    hold_out = 200;
    repeat (40) send_transaction(les_pkg::ModeAdvance, 16'($urandom_range(65535, 1)));
    settle_levels();
    idle_on = 1'b1;

    counted = 0;
    while (counted < 1700) begin
      eff = ($urandom_range(9, 0) == 0) ? $urandom_range(7, 6) : $urandom_range(5, 0);
      sel = $urandom_range(9, 0);
      case (sel)
        0: per = 16'd0;
        1: per = 16'hffff;
        2: per = 16'($urandom_range(65535, 1));
        default: per = 16'($urandom_range(64, 1));
      endcase
      on_t = 16'($urandom_range(32'(per) + 2, 0));
      dly_b = ($urandom_range(7, 0) == 0) ? 16'($urandom_range(65535, 0)) :
                                            16'($urandom_range(20, 0));
      sel = $urandom_range(5, 0);
      if (sel == 0) dly_a = 16'($urandom_range(65535, 0));
      else if (sel < 3) dly_a = 16'd0;
      else dly_a = 16'($urandom_range(10, 0));
      sel = $urandom_range(9, 0);
      case (sel)
        0: reps = 16'd0;
        1, 2: reps = les_pkg::ForeverCount;
        3: reps = 16'($urandom_range(65535, 0));
        default: reps = 16'($urandom_range(5, 1));
      endcase
      ctl[4:3] = 2'($urandom_range(3, 0));
      ctl[2:0] = 3'(eff);
      configure(ctl, per, on_t, dly_b, dly_a, reps, {$urandom, $urandom},
                8'($urandom_range(255, 0)));

      cyc = ((eff <= 32'(les_pkg::EffOn) || per == 16'd0) ? 32'd1 : 32'(per)) + 32'(dly_a);
      step_max = cyc / 6;
      if (32'(dly_b) / 8 > step_max) step_max = 32'(dly_b) / 8;
      if (step_max == 0) step_max = 1;
      if (step_max > 65535) step_max = 65535;
      idle_on = ($urandom_range(3, 0) != 0);
      n = $urandom_range(80, 30);
      repeat (n) begin
        el = 16'($urandom_range(step_max, 1));
        md = les_pkg::ModeAdvance;
        sel = $urandom_range(99, 0);
        if (!levels.active && sel >= 20) begin
          md = les_pkg::ModeStart;
        end else if (sel < 3) begin
          md = les_pkg::ModeStop;
        end else if (sel < 5) begin
          md = les_pkg::ModeStart;
        end else if (sel < 7) begin
          md = ModeIgnored;
          el = 16'($urandom);
        end else if (sel < 10) begin
          el = 16'd0;
        end else if (sel < 14) begin
          el = 16'($urandom_range(65535, 1));
        end
        counted++;
        send_transaction(md, el);
        if ($urandom_range(39, 0) == 0) settle_levels();
      end
    end

    settle_levels();
    if (levels.mismatches == 0 && levels.due_levels.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
